// File: design/cqfi_pkg.sv
`default_nettype none
package cqfi_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int VALUE_WIDTH = 16;

	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W   = PTR_W + 1;
	localparam int OCC_W   = 7;
	localparam int FIELD_W = 16;

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [PTR_W-1:0]       ptr_t;
	typedef logic [COUNT_W-1:0]     count_t;
	typedef logic [SUM_W-1:0]       sum_t;
	typedef logic [OCC_W-1:0]       occ_t;
	typedef logic [FIELD_W-1:0]     field_t;

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_READ   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic    load;
		logic    push_tail;
		logic    push_head;
		logic    pop;
		logic    rd;
		status_t result;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dp_status_t;

endpackage
`default_nettype wire

// File: design/cqfi_in_if.sv
`default_nettype none
interface cqfi_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] item_value;

	modport source (output valid, output action, output item_value, input ready);
	modport sink (input valid, input action, input item_value, output ready);
endinterface
`default_nettype wire

// File: design/cqfi_out_if.sv
`default_nettype none
interface cqfi_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] head_value;
	logic [1:0]  status;
	logic        now_empty;
	logic [6:0]  occupancy;

	modport source (output valid, output head_value, output status, output now_empty,
		output occupancy, input ready);
	modport sink (input valid, input head_value, input status, input now_empty,
		input occupancy, output ready);
endinterface
`default_nettype wire

// File: design/cqfi_ram.sv
`default_nettype none
module cqfi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: design/cqfi_ctrl.sv
`default_nettype none
module cqfi_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic [1:0]           action,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire cqfi_pkg::dp_status_t stat,
	output cqfi_pkg::cmd_t            cmd
);

	typedef enum logic {
		S_IDLE,
		S_RESP
	} state_t;

	state_t             state_q;
	cqfi_pkg::action_t  act;
	logic               take;

	assign act       = cqfi_pkg::action_t'(action);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_RESP);
	assign take      = in_valid && in_ready;

	always_comb begin
		cmd           = '0;
		cmd.result    = cqfi_pkg::ST_DONE;
		cmd.load      = take;
		case (act)
			cqfi_pkg::ACT_APPEND, cqfi_pkg::ACT_INSERT: begin
				if (stat.full) begin
					cmd.result = cqfi_pkg::ST_OVERFLOW;
				end else begin
					cmd.push_tail = take && (act == cqfi_pkg::ACT_APPEND);
					cmd.push_head = take && (act == cqfi_pkg::ACT_INSERT);
				end
			end
			cqfi_pkg::ACT_REMOVE, cqfi_pkg::ACT_READ: begin
				if (stat.empty) begin
					cmd.result = cqfi_pkg::ST_UNDERFLOW;
				end else begin
					cmd.rd  = take;
					cmd.pop = take && (act == cqfi_pkg::ACT_REMOVE);
				end
			end
			default: begin
				cmd.result = cqfi_pkg::ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: design/cqfi_datapath.sv
`default_nettype none
module cqfi_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cqfi_pkg::cmd_t   cmd,
	input  wire logic [15:0]      item_value,
	output cqfi_pkg::dp_status_t  stat,
	output logic [15:0]           head_value,
	output logic [1:0]            status,
	output logic                  now_empty,
	output logic [6:0]            occupancy
);

	cqfi_pkg::ptr_t    head_q;
	cqfi_pkg::count_t  count_q;
	cqfi_pkg::status_t status_q;
	logic              show_q;
	cqfi_pkg::sum_t    tail_sum;
	cqfi_pkg::ptr_t    tail_ptr;
	cqfi_pkg::ptr_t    head_prev;
	cqfi_pkg::ptr_t    head_next;
	cqfi_pkg::ptr_t    waddr;
	cqfi_pkg::value_t  rdata;
	logic              we;

	assign stat.full  = (count_q == cqfi_pkg::count_t'(cqfi_pkg::QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

	// wrap without a divider: sum stays below twice the depth
	assign tail_sum = cqfi_pkg::sum_t'(head_q) + cqfi_pkg::sum_t'(count_q);
	assign tail_ptr = (tail_sum >= cqfi_pkg::sum_t'(cqfi_pkg::QUEUE_DEPTH))
		? cqfi_pkg::ptr_t'(tail_sum - cqfi_pkg::sum_t'(cqfi_pkg::QUEUE_DEPTH))
		: cqfi_pkg::ptr_t'(tail_sum);
	assign head_prev = (head_q == '0)
		? cqfi_pkg::ptr_t'(cqfi_pkg::QUEUE_DEPTH - 1) : head_q - 1'b1;
	assign head_next = (head_q == cqfi_pkg::ptr_t'(cqfi_pkg::QUEUE_DEPTH - 1))
		? '0 : head_q + 1'b1;

	assign we    = cmd.push_tail || cmd.push_head;
	assign waddr = cmd.push_head ? head_prev : tail_ptr;

	cqfi_ram #(
		.WIDTH(cqfi_pkg::VALUE_WIDTH),
		.DEPTH(cqfi_pkg::QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (cqfi_pkg::value_t'(item_value)),
		.re    (cmd.rd),
		.raddr (head_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.push_head) begin
				head_q <= head_prev;
			end else if (cmd.pop) begin
				head_q <= head_next;
			end
			if (we) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q <= cmd.result;
			show_q   <= cmd.rd;
		end
	end

	assign head_value = show_q ? cqfi_pkg::field_t'(rdata) : '0;
	assign status     = status_q;
	assign now_empty  = (count_q == '0);
	assign occupancy  = cqfi_pkg::occ_t'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cqfi_pkg::count_t'(cqfi_pkg::QUEUE_DEPTH))
		else $error("entry count beyond depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_tail || cmd.push_head) |-> !stat.full)
		else $error("push into full queue");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> (count_q == $past(count_q) - 1'b1))
		else $error("remove did not lower count");

	a_insert_head: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_head |=> (head_q == $past(head_prev)))
		else $error("head insert did not step head back");

endmodule
`default_nettype wire

// File: design/circular_queue_with_front_insert_unit.sv
`default_nettype none
// Circular queue of cqfi_pkg::QUEUE_DEPTH entries that takes append, head insert, remove and
// read actions and returns one result per action with status, empty flag and occupancy. An
// action is accepted while the unit is idle and its result is offered from the next cycle on;
// the next action is accepted the cycle after that result transfers, so a new action is not
// taken while a result waits. This follows from the registered read of the entry memory
// and from the controller, which holds one action until its result is taken.
// Entries are not cleared at reset; only written entries are ever read.
module circular_queue_with_front_insert_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	cqfi_in_if.sink   item,
	cqfi_out_if.source result
);

	cqfi_pkg::cmd_t       cmd;
	cqfi_pkg::dp_status_t stat;

	cqfi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.action    (item.action),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cqfi_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.item_value (item.item_value),
		.stat       (stat),
		.head_value (result.head_value),
		.status     (result.status),
		.now_empty  (result.now_empty),
		.occupancy  (result.occupancy)
	);

endmodule
`default_nettype wire
